>>> src/dra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dra_pkg
// Shared types and codes of the dated ring accumulator.
// ----------------------------------------------------------------------------
package dra_pkg;

	localparam int DATE_W  = 16;
	localparam int COUNT_W = 16;
	localparam int TOTAL_W = 32;

	localparam logic [COUNT_W-1:0] DAY_FIELD_MAX = 16'hFFFF;

	// item kinds carried on the input tuser
	localparam logic [1:0] MODE_RECORD = 2'd0;
	localparam logic [1:0] MODE_LOOKUP = 2'd1;
	localparam logic [1:0] MODE_WINDOW = 2'd2;

	// one ring entry as held in the memory
	typedef struct packed {
		logic [DATE_W-1:0]  date;
		logic [COUNT_W-1:0] sessions;
		logic [COUNT_W-1:0] minutes;
	} day_rec_t;

	// one result from the engine to the output register
	typedef struct packed {
		logic               found;
		logic [DATE_W-1:0]  date;
		logic [COUNT_W-1:0] sessions;
		logic [COUNT_W-1:0] minutes;
		logic [TOTAL_W-1:0] all_sessions;
		logic [TOTAL_W-1:0] all_minutes;
		logic               last;
	} dra_result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_EMIT
	} eng_state_t;

endpackage
`default_nettype wire

>>> src/dra_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dra_engine
// Ring memory, newest-first scan, read-modify-write of one record, totals.
// ----------------------------------------------------------------------------
module dra_engine import dra_pkg::*; #(
	parameter int RING_DAYS   = 32,
	parameter int WINDOW_DAYS = 7
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [DATE_W-1:0]   cfg_wdata,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [1:0]          s_mode,
	input  wire logic [DATE_W-1:0]   s_day,
	input  wire logic [COUNT_W-1:0]  s_mins,
	output logic                     res_valid,
	input  wire logic                res_ready,
	output dra_result_t              res
);

	localparam int AW = (RING_DAYS > 1) ? $clog2(RING_DAYS) : 1;
	localparam int CW = $clog2(RING_DAYS + 1);
	localparam int KW = (WINDOW_DAYS > 1) ? $clog2(WINDOW_DAYS) : 1;

	function automatic logic [DATE_W-1:0] win_date(input logic [DATE_W-1:0] today,
		input logic [6:0] back);
		logic [DATE_W:0] diff;
		diff = {1'b0, today} - {10'd0, back};
		win_date = diff[DATE_W] ? '0 : diff[DATE_W-1:0];
	endfunction

	eng_state_t          state_q, state_d;
	logic [1:0]          mode_q;
	logic [DATE_W-1:0]   day_q, target_q, no_date_q;
	logic [COUNT_W-1:0]  mins_q;
	logic [KW-1:0]       k_q;
	logic [TOTAL_W-1:0]  sum_sess_q, sum_min_q;
	logic [AW-1:0]       newest_q, scan_slot_q, slot_s1, wr_slot_q;
	logic [CW-1:0]       used_q, back_q;
	logic                pend_s1, first_s1, found_q, app_q;
	day_rec_t            rec_q, rd_data_s1, bumped;
	day_rec_t            ring_mem [RING_DAYS];

	logic                in_fire, hit, stop_less, more, scan_issue, scan_done;
	logic                is_record, do_append, k_last, more_window;
	logic                rd_en, wr_en;
	logic [AW-1:0]       next_slot, prev_slot;
	logic [COUNT_W:0]    min_sum;

	assign in_fire     = s_tvalid && s_tready;
	assign hit         = pend_s1 && (rd_data_s1.date == target_q);
	assign stop_less   = pend_s1 && (rd_data_s1.date < target_q);
	assign more        = back_q < used_q;
	assign scan_issue  = (state_q == ST_SCAN) && !hit && !stop_less && more;
	assign scan_done   = hit || stop_less || (!pend_s1 && !more);
	assign is_record   = mode_q == MODE_RECORD;
	// a newer date than the newest record: append over the oldest slot
	assign do_append   = is_record && stop_less && first_s1;
	assign k_last      = k_q == KW'(WINDOW_DAYS - 1);
	assign more_window = (mode_q == MODE_WINDOW) && !k_last;
	assign next_slot   = (newest_q == AW'(RING_DAYS - 1)) ? '0 : newest_q + 1'b1;
	assign prev_slot   = (scan_slot_q == '0) ? AW'(RING_DAYS - 1) : scan_slot_q - 1'b1;

	// saturate the count, add minutes only if they fit
	assign min_sum = {1'b0, rd_data_s1.minutes} + {1'b0, mins_q};
	always_comb begin
		bumped          = rd_data_s1;
		bumped.sessions = (rd_data_s1.sessions == DAY_FIELD_MAX) ?
			rd_data_s1.sessions : rd_data_s1.sessions + 1'b1;
		bumped.minutes  = min_sum[COUNT_W] ? rd_data_s1.minutes : min_sum[COUNT_W-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					case (s_mode)
						MODE_RECORD: begin
							if (s_day == no_date_q) begin
								state_d = ST_EMIT;
							end else if (used_q == '0) begin
								state_d = ST_WRITE;
							end else begin
								state_d = ST_SCAN;
							end
						end
						MODE_LOOKUP, MODE_WINDOW: state_d = ST_SCAN;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					if ((hit && is_record) || do_append) begin
						state_d = ST_WRITE;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_WRITE: state_d = ST_EMIT;
			ST_EMIT: begin
				if (res_ready) begin
					state_d = more_window ? ST_SCAN : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready         = state_q == ST_IDLE;
		res_valid        = state_q == ST_EMIT;
		rd_en            = scan_issue;
		wr_en            = state_q == ST_WRITE;
		res.found        = found_q;
		res.date         = target_q;
		res.sessions     = found_q ? rec_q.sessions : '0;
		res.minutes      = found_q ? rec_q.minutes : '0;
		res.all_sessions = sum_sess_q;
		res.all_minutes  = sum_min_q;
		res.last         = !more_window;
	end

	// ring memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[wr_slot_q] <= rec_q;
		end
		if (rd_en) begin
			rd_data_s1 <= ring_mem[scan_slot_q];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			no_date_q  <= '0;
			sum_sess_q <= '0;
			sum_min_q  <= '0;
			newest_q   <= '0;
			used_q     <= '0;
			back_q     <= '0;
			pend_s1    <= 1'b0;
			k_q        <= '0;
		end else begin
			state_q <= state_d;
			pend_s1 <= scan_issue;
			if (cfg_we) begin
				no_date_q <= cfg_wdata;
			end
			if (in_fire && (s_mode == MODE_RECORD)) begin
				sum_sess_q <= sum_sess_q + 1'b1;
				sum_min_q  <= sum_min_q + {16'd0, s_mins};
			end
			if (in_fire) begin
				back_q <= '0;
				k_q    <= '0;
			end
			if (scan_issue) begin
				back_q <= back_q + 1'b1;
			end
			if ((state_q == ST_EMIT) && res_ready && more_window) begin
				back_q <= '0;
				k_q    <= k_q + 1'b1;
			end
			if ((state_q == ST_WRITE) && app_q) begin
				newest_q <= wr_slot_q;
				if (used_q != CW'(RING_DAYS)) begin
					used_q <= used_q + 1'b1;
				end
			end
		end
	end

	// item payload and scan bookkeeping
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q      <= s_mode;
			day_q       <= s_day;
			mins_q      <= s_mins;
			scan_slot_q <= newest_q;
			found_q     <= 1'b0;
			app_q       <= 1'b1;
			wr_slot_q   <= next_slot;
			rec_q       <= '{date: s_day, sessions: 16'd1, minutes: s_mins};
			target_q    <= (s_mode == MODE_WINDOW) ?
				win_date(s_day, 7'(WINDOW_DAYS - 1)) : s_day;
		end
		if (state_q == ST_WRITE) begin
			found_q <= 1'b1;
		end
		if (scan_issue) begin
			slot_s1     <= scan_slot_q;
			first_s1    <= back_q == '0;
			scan_slot_q <= prev_slot;
		end
		if ((state_q == ST_SCAN) && scan_done) begin
			found_q <= hit;
			if (hit) begin
				app_q     <= 1'b0;
				wr_slot_q <= slot_s1;
				rec_q     <= is_record ? bumped : rd_data_s1;
			end else if (do_append) begin
				app_q     <= 1'b1;
				wr_slot_q <= next_slot;
				rec_q     <= '{date: target_q, sessions: 16'd1, minutes: mins_q};
			end
		end
		if ((state_q == ST_EMIT) && res_ready && more_window) begin
			scan_slot_q <= newest_q;
			target_q    <= win_date(day_q, 7'(WINDOW_DAYS - 1) - 7'(k_q) - 7'd1);
		end
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(RING_DAYS))
		else $error("fill count beyond ring depth");

	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("ring read and write in the same cycle");

	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (s_mode == MODE_RECORD)) |=> (sum_sess_q == $past(sum_sess_q) + 32'd1))
		else $error("session total did not advance on a record transaction");

	a_newest_move: assert property (@(posedge clk) disable iff (!arst_n)
		(newest_q != $past(newest_q)) |-> $past((state_q == ST_WRITE) && app_q))
		else $error("newest slot moved outside an append");

endmodule
`default_nettype wire

>>> src/dated_ring_accumulator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dated_ring_accumulator_core
// Per-date session ring with running totals, stream in / stream out.
// ----------------------------------------------------------------------------
// Keeps up to RING_DAYS dated records (date, sessions, minutes) in a ring
// memory, oldest to newest in ascending date order, plus two 32-bit totals
// that wrap. One item is handled at a time. A lookup walks the ring
// newest-first through the single read port of the memory, one entry per
// cycle, and stops at the first entry at or below the wanted date or once
// it runs past the oldest entry. A record item runs one such lookup plus a
// write-back of the updated or appended record; an item carrying the
// no-date code skips the ring. A window query runs WINDOW_DAYS lookups
// back to back and returns one transaction per date, oldest first, with
// tlast on the final one. Mode 3 is accepted and produces nothing. The ring
// needs no clearing after reset: the fill count keeps unwritten entries
// from being read. Results pass through an output register, so a finished
// result may wait on m_tready while the core goes on. Write the no-date
// code only while the core is idle.
// ----------------------------------------------------------------------------
module dated_ring_accumulator_core import dra_pkg::*; #(
	parameter int RING_DAYS   = 32,
	parameter int WINDOW_DAYS = 7
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [15:0]   cfg_wdata,   // no_date_code
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [31:0]   s_tdata,     // day_number[15:0], session_minutes[31:16]
	input  wire logic [1:0]    s_tuser,     // mode[1:0]
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [111:0]       m_tdata,     // reported_date[15:0], day_sessions[31:16],
	                                        // day_minutes[47:32], all_sessions[79:48],
	                                        // all_minutes[111:80]
	output logic [0:0]         m_tuser,     // found[0]
	output logic               m_tlast      // last_of_run
);

	logic        res_valid, res_ready;
	dra_result_t res, res_q;
	logic        m_tvalid_q;

	dra_engine #(
		.RING_DAYS   (RING_DAYS),
		.WINDOW_DAYS (WINDOW_DAYS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_mode    (s_tuser),
		.s_day     (s_tdata[15:0]),
		.s_mins    (s_tdata[31:16]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// take a new result whenever the output register is empty or draining
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	// hold the payload until the transaction completes
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {res_q.all_minutes, res_q.all_sessions, res_q.minutes,
		res_q.sessions, res_q.date};
	assign m_tuser  = res_q.found;
	assign m_tlast  = res_q.last;

endmodule
`default_nettype wire

>>> test/tb_dated_ring_accumulator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dated_ring_accumulator_core
// Self-checking stream testbench for the dated ring accumulator core.
// ----------------------------------------------------------------------------
// A queue of session items (record, lookup, seven-day window, unused kind)
// feeds a clocked driver that raises s_tvalid with random gaps. Each accepted
// transaction runs through a behavioral copy of the ring and its totals,
// which queues the reports the core should return. A clocked block stalls
// m_tready at random, and a clocked monitor compares every returned report,
// field by field, with the oldest queued one. The no-date code is rewritten
// between phases, once the core has gone quiet. The run covers empty-ring
// lookups, window clamping near date 0, minutes that do not fit, a burst on
// one date whose minutes stop fitting, ring wrap past RING_DAYS dates, and
// dates at the top of the 16-bit range.
// ----------------------------------------------------------------------------
module tb_dated_ring_accumulator_core;
	import dra_pkg::*;

	localparam int RING = 32;
	localparam int WIN  = 7;
	// cycles to let pass after the last report: one full ring walk plus margin
	localparam int TAIL = RING + 16;
	localparam longint LIMIT_NS = 64'd80_000_000;
	// the fourth item kind: accepted and ignored by the core
	localparam logic [1:0] MODE_SPARE = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] day;
		logic [15:0] mins;
	} session_item_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          cfg_we = 1'b0;
	logic [15:0]   cfg_wdata = '0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [31:0]   s_tdata = '0;     // day_number[15:0], session_minutes[31:16]
	logic [1:0]    s_tuser = '0;     // mode[1:0]
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [111:0]  m_tdata;          // reported_date, day_sessions, day_minutes,
	                                 // all_sessions, all_minutes
	logic [0:0]    m_tuser;          // found[0]
	logic          m_tlast;          // last_of_run

	dated_ring_accumulator_core #(
		.RING_DAYS   (RING),
		.WINDOW_DAYS (WIN)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// --------------------------------------------------------------------
	// Shadow of the core state, updated on every accepted transaction
	// --------------------------------------------------------------------
	day_rec_t    ring_mem [RING] = '{default: '0};
	int unsigned newest_idx = 0;
	int unsigned fill_cnt = 0;
	logic [31:0] total_sessions = '0;
	logic [31:0] total_minutes = '0;
	logic [15:0] skip_code = '0;

	session_item_t sessions_to_send [$];
	dra_result_t   pending_reports [$];
	int            err_count = 0;

	// stimulus-side view of the newest date and the current no-date code
	int            top_date = 0;
	logic [15:0]   cur_code = '0;
	// set to switch off all idling on both sides
	bit            quiet = 1'b0;

	function automatic int ring_back(int back);
		return (newest_idx + RING - back) % RING;
	endfunction

	// walk newest-first, stop once below the wanted date
	function automatic int locate_day(logic [15:0] d);
		int i;
		for (int back = 0; back < fill_cnt; back++) begin
			i = ring_back(back);
			if (ring_mem[i].date == d)
				return i;
			if (ring_mem[i].date < d)
				return -1;
		end
		return -1;
	endfunction

	// saturate the count, add minutes only when they fit
	function automatic void bump_day(int i, logic [15:0] m);
		if (ring_mem[i].sessions != DAY_FIELD_MAX)
			ring_mem[i].sessions = ring_mem[i].sessions + 16'd1;
		if ({1'b0, ring_mem[i].minutes} + {1'b0, m} <= 17'h0FFFF)
			ring_mem[i].minutes = ring_mem[i].minutes + m;
	endfunction

	function automatic int log_session(logic [15:0] d, logic [15:0] m);
		int i;
		total_sessions = total_sessions + 32'd1;
		total_minutes = total_minutes + {16'd0, m};
		if (d == skip_code)
			return -1;
		if (fill_cnt > 0) begin
			if (ring_mem[newest_idx].date == d) begin
				bump_day(newest_idx, m);
				return newest_idx;
			end
			if (d < ring_mem[newest_idx].date) begin
				for (int back = 1; back < fill_cnt; back++) begin
					i = ring_back(back);
					if (ring_mem[i].date == d) begin
						bump_day(i, m);
						return i;
					end
				end
				return -1;
			end
		end
		// newer than everything held: append over the oldest
		newest_idx = (newest_idx + 1) % RING;
		ring_mem[newest_idx].date = d;
		ring_mem[newest_idx].sessions = 16'd1;
		ring_mem[newest_idx].minutes = m;
		if (fill_cnt < RING)
			fill_cnt++;
		return newest_idx;
	endfunction

	function automatic dra_result_t report_day(int slot, logic [15:0] d, bit last);
		dra_result_t r;
		r = '0;
		r.date = d;
		if (slot >= 0) begin
			r.found = 1'b1;
			r.sessions = ring_mem[slot].sessions;
			r.minutes = ring_mem[slot].minutes;
		end
		r.all_sessions = total_sessions;
		r.all_minutes = total_minutes;
		r.last = last;
		return r;
	endfunction

	function automatic void predict_reports(logic [1:0] mode, logic [15:0] d,
	                                        logic [15:0] m);
		int dd;
		case (mode)
			MODE_RECORD: begin
				pending_reports.push_back(report_day(log_session(d, m), d, 1'b1));
			end
			MODE_LOOKUP: begin
				pending_reports.push_back(report_day(locate_day(d), d, 1'b1));
			end
			MODE_WINDOW: begin
				// oldest date first, clamped at zero
				for (int k = 0; k < WIN; k++) begin
					dd = int'(d) - (WIN - 1 - k);
					if (dd < 0)
						dd = 0;
					pending_reports.push_back(
						report_day(locate_day(16'(dd)), 16'(dd), k == WIN - 1));
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void check_field(string name, logic [31:0] want,
	                                    logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			err_count++;
		end
	endfunction

	// mostly short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 65)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// --------------------------------------------------------------------
	// Driver: change inputs at the falling edge
	// --------------------------------------------------------------------
	bit            in_fired = 1'b0;
	int unsigned   send_gap = 0;
	int unsigned   hold_cnt = 0;
	session_item_t next_item;

	always @(negedge clk) begin
		// hold the current transaction until the core takes it
		if (!s_tvalid || in_fired) begin
			if (send_gap != 0) begin
				s_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (sessions_to_send.size() != 0) begin
				next_item = sessions_to_send.pop_front();
				s_tdata <= {next_item.mins, next_item.day};
				s_tuser <= next_item.mode;
				s_tvalid <= 1'b1;
				send_gap <= pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// stall the result side at random
	always @(negedge clk) begin
		if (hold_cnt != 0) begin
			m_tready <= 1'b0;
			hold_cnt <= hold_cnt - 1;
		end else begin
			m_tready <= 1'b1;
			hold_cnt <= pick_gap();
		end
	end

	// --------------------------------------------------------------------
	// Monitor: sample at the rising edge, check reports, then predict
	// --------------------------------------------------------------------
	dra_result_t want_rep;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_reports.size() == 0) begin
					$error("report for date 0x%0h arrived with none outstanding",
					       m_tdata[15:0]);
					err_count++;
				end else begin
					want_rep = pending_reports.pop_front();
					check_field("found", want_rep.found, m_tuser[0]);
					check_field("reported_date", want_rep.date, m_tdata[15:0]);
					check_field("day_sessions", want_rep.sessions, m_tdata[31:16]);
					check_field("day_minutes", want_rep.minutes, m_tdata[47:32]);
					check_field("all_sessions", want_rep.all_sessions, m_tdata[79:48]);
					check_field("all_minutes", want_rep.all_minutes, m_tdata[111:80]);
					check_field("last_of_run", want_rep.last, m_tlast);
				end
			end
			if (s_tvalid && s_tready)
				predict_reports(s_tuser, s_tdata[15:0], s_tdata[31:16]);
			if (cfg_we)
				skip_code = cfg_wdata;
		end
		in_fired <= s_tvalid && s_tready;
	end

	// --------------------------------------------------------------------
	// Stimulus
	// --------------------------------------------------------------------
	task automatic push_item(logic [1:0] mode, logic [15:0] d, logic [15:0] m);
		session_item_t it;
		it.mode = mode;
		it.day = d;
		it.mins = m;
		sessions_to_send.push_back(it);
	endtask

	task automatic write_code(logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_code = v;
	endtask

	// wait until everything is sent and answered, then let a mode-3 item drain
	task automatic settle();
		while (sessions_to_send.size() != 0 || s_tvalid || pending_reports.size() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);
	endtask

	function automatic logic [15:0] below_top(int span);
		int d;
		d = top_date - int'($urandom_range(0, span));
		return (d < 0) ? 16'd0 : 16'(d);
	endfunction

	task automatic gen_random(int n);
		int unsigned r;
		int unsigned rm;
		logic [15:0] m;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			rm = $urandom_range(0, 9);
			if (rm < 6)
				m = 16'($urandom_range(0, 120));
			else if (rm < 8)
				m = 16'($urandom_range(0, 65535));
			else if (rm == 8)
				m = 16'hFFFF;
			else
				m = 16'($urandom_range(60000, 65535));
			if (r < 30) begin
				// newer date: appends, wraps the ring once past RING dates
				top_date = top_date + int'($urandom_range(1, 3));
				if (top_date > 65535)
					top_date = 65535;
				push_item(MODE_RECORD, 16'(top_date), m);
			end else if (r < 45) begin
				push_item(MODE_RECORD, 16'(top_date), m);
			end else if (r < 58) begin
				push_item(MODE_RECORD, below_top(40), m);
			end else if (r < 62) begin
				push_item(MODE_RECORD, cur_code, m);
			end else if (r < 78) begin
				if ($urandom_range(0, 5) == 0)
					push_item(MODE_LOOKUP, 16'($urandom_range(0, 65535)), m);
				else
					push_item(MODE_LOOKUP, below_top(45), m);
			end else if (r < 96) begin
				if ($urandom_range(0, 5) == 0)
					push_item(MODE_WINDOW, 16'($urandom_range(0, 65535)), m);
				else
					push_item(MODE_WINDOW, below_top(12), m);
			end else begin
				push_item(MODE_SPARE, 16'($urandom_range(0, 65535)), m);
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty ring, clamping, fit and drop cases, unused kind
		write_code(16'hFFFF);
		push_item(MODE_LOOKUP, 16'd5, 16'd0);
		push_item(MODE_WINDOW, 16'd3, 16'd0);
		push_item(MODE_RECORD, 16'd0, 16'd7);
		push_item(MODE_RECORD, 16'd2, 16'hFFFF);
		push_item(MODE_RECORD, 16'd2, 16'd1);
		push_item(MODE_RECORD, 16'd2, 16'd0);
		push_item(MODE_RECORD, 16'd5, 16'd100);
		push_item(MODE_RECORD, 16'd3, 16'd9);
		push_item(MODE_RECORD, 16'd0, 16'd4);
		push_item(MODE_RECORD, 16'hFFFF, 16'd50);
		push_item(MODE_LOOKUP, 16'd2, 16'd0);
		push_item(MODE_LOOKUP, 16'd4, 16'd0);
		push_item(MODE_LOOKUP, 16'd0, 16'd0);
		push_item(MODE_WINDOW, 16'd2, 16'd0);
		push_item(MODE_WINDOW, 16'd6, 16'd0);
		push_item(MODE_SPARE, 16'hFFFF, 16'hFFFF);
		push_item(MODE_RECORD, 16'd5, 16'hFFFF);
		push_item(MODE_RECORD, 16'd20, 16'd0);
		push_item(MODE_LOOKUP, 16'hFFFF, 16'd0);
		push_item(MODE_WINDOW, 16'hFFFF, 16'd0);
		top_date = 20;
		settle();

		// burst on one date: its minutes stop fitting, the count keeps climbing
		write_code(16'h0000);
		quiet = 1'b1;
		for (int i = 0; i < 24; i++)
			push_item(MODE_RECORD, 16'd20, 16'hFFFF);
		push_item(MODE_RECORD, 16'd0, 16'd3);
		push_item(MODE_LOOKUP, 16'd0, 16'd0);
		push_item(MODE_LOOKUP, 16'd20, 16'd0);
		settle();
		quiet = 1'b0;

		// random phases under changing no-date codes
		for (int p = 0; p < 4; p++) begin
			if (p == 3)
				top_date = 16'hFFC0;
			if (p % 2 == 0)
				write_code(16'(top_date + int'($urandom_range(0, 8))));
			else
				write_code(16'($urandom_range(0, 65535)));
			quiet = (p == 2);
			gen_random(100);
			settle();
		end

		// top of the date range
		quiet = 1'b0;
		write_code(16'h0001);
		push_item(MODE_RECORD, 16'hFFFF, 16'd12);
		push_item(MODE_RECORD, 16'hFFFF, 16'hFFFF);
		push_item(MODE_RECORD, 16'hFFFE, 16'd1);
		push_item(MODE_LOOKUP, 16'hFFFF, 16'd0);
		push_item(MODE_WINDOW, 16'hFFFF, 16'd0);
		settle();

		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#(LIMIT_NS);
		$display("Test completed with failures");
		$finish;
	end

endmodule
